[rtl/led_ripple_frame_shifter_defines.svh]
// Assertion macros for the LED ripple frame shifter.
`ifndef LED_RIPPLE_FRAME_SHIFTER_DEFINES_SVH
`define LED_RIPPLE_FRAME_SHIFTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LRFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrfs assertion failed");
// next-cycle implication
`define LRFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrfs assertion failed");
`else
`define LRFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LRFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/lrfs_pkg.sv]
// Shared types, constants and the cell source-select function.
`timescale 1ns / 1ps

package lrfs_pkg;

	localparam int LED_COUNT_DEF = 32;
	localparam int PIX_INDEX_W   = 6;
	localparam int CFG_INDEX_W   = 8;
	localparam int CFG_DATA_W    = 9;
	localparam int SLOT_W        = 9;
	localparam logic [7:0] BRIGHTNESS_RST = 8'd255;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_RIPPLE_MODE     = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS_SLOT = 8'd1;

	// func field codes
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_SLOT = 1'b1;

	typedef enum logic [1:0] {
		MODE_TO_HIGH = 2'd0,
		MODE_TO_LOW  = 2'd1,
		MODE_OUTWARD = 2'd2,
		MODE_INWARD  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		SRC_LOW,
		SRC_HIGH,
		SRC_FILL
	} src_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_t;

	typedef struct packed {
		mode_t mode;
		logic  apply;     // shift frame, load readout
		logic  ro_shift;  // advance readout toward index 0
	} cell_ctrl_t;

	// Where cell idx takes its next pixel from in a given mode.
	function automatic src_t cell_src(mode_t mode, int idx, int n);
		int   h;
		src_t s;
		h = n >> 1;
		s = SRC_FILL;
		unique case (mode)
			MODE_TO_HIGH: s = (idx == 0) ? SRC_FILL : SRC_LOW;
			MODE_TO_LOW:  s = (idx == n - 1) ? SRC_FILL : SRC_HIGH;
			MODE_OUTWARD: begin
				if (idx < h - 1)
					s = SRC_HIGH;
				else if (idx > n - h)
					s = SRC_LOW;
				else
					s = SRC_FILL;
			end
			MODE_INWARD: begin
				if (idx == 0 || idx == n - 1)
					s = SRC_FILL;
				else if (idx < h)
					s = SRC_LOW;
				else
					s = SRC_HIGH;
			end
		endcase
		return s;
	endfunction

endpackage

[rtl/lrfs_scale.sv]
// Brightness scaler stage: scales the tick color and holds it until the frame takes it.
`timescale 1ns / 1ps

module lrfs_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic            advance,
	input  logic [7:0]      brightness,
	input  logic [7:0]      red,
	input  logic [7:0]      green,
	input  logic [7:0]      blue,
	output logic            valid_s1,
	output lrfs_pkg::pixel_t fill_s1
);
	import lrfs_pkg::*;

	logic [8:0]  gain;
	logic [16:0] prod_r, prod_g, prod_b;

	assign gain   = {1'b0, brightness} + 9'd1;
	assign prod_r = {9'd0, red}   * {8'd0, gain};
	assign prod_g = {9'd0, green} * {8'd0, gain};
	assign prod_b = {9'd0, blue}  * {8'd0, gain};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fill_s1.r <= prod_r[15:8];
			fill_s1.g <= prod_g[15:8];
			fill_s1.b <= prod_b[15:8];
		end
	end

endmodule

[rtl/lrfs_cell.sv]
// One LED position: frame pixel register plus readout register.
`timescale 1ns / 1ps

module lrfs_cell #(
	parameter int INDEX     = 0,
	parameter int LED_COUNT = lrfs_pkg::LED_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lrfs_pkg::cell_ctrl_t ctrl,
	input  lrfs_pkg::pixel_t     fill,
	input  lrfs_pkg::pixel_t     low_px,
	input  lrfs_pkg::pixel_t     high_px,
	input  lrfs_pkg::pixel_t     ro_in,
	output lrfs_pkg::pixel_t     px_q,
	output lrfs_pkg::pixel_t     ro_q
);
	import lrfs_pkg::*;

	pixel_t nxt;

	always_comb begin
		unique case (cell_src(ctrl.mode, INDEX, LED_COUNT))
			SRC_LOW:  nxt = low_px;
			SRC_HIGH: nxt = high_px;
			SRC_FILL: nxt = fill;
			default:  nxt = fill;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			px_q <= '0;
		else if (ctrl.apply)
			px_q <= nxt;
	end

	// readout copy: loaded with the new frame, then walks toward cell 0
	always_ff @(posedge clk) begin
		if (ctrl.apply)
			ro_q <= nxt;
		else if (ctrl.ro_shift)
			ro_q <= ro_in;
	end

endmodule

[rtl/led_ripple_frame_shifter.sv]
// Top level of the LED ripple frame shifter.
`timescale 1ns / 1ps
`include "led_ripple_frame_shifter_defines.svh"
// Usage:
//  Input channel (in_valid/in_stall): func=1 requests carry a control slot byte;
//   when slot_index equals brightness_slot, brightness takes slot_value. They
//   produce no output. func=0 requests are ticks carrying a color.
//  A tick is scaled per channel by (v*(1+brightness))>>8 on acceptance; once the
//   readout chain is free, the frame shifts in ripple_mode and takes that color.
//  Output channel (out_valid/out_stall): the whole frame, pixel 0 first, one
//   request per pixel, frame_last on pixel LED_COUNT-1.
//  Path: an accepted tick goes through the scale stage, then the frame load,
//   after which its first pixel is shown.
//  Readout: the readout chain of cells moves one pixel per cycle toward cell 0
//   while out_stall is low. The next tick is taken and scaled while the current
//   frame still drains, and loads as its last pixel leaves, so frames follow
//   without a gap.
//  Stall: out_stall freezes the readout chain; once the scale stage holds a
//   waiting tick, in_stall rises and holds off all input requests.
//  Config (cfg_valid/cfg_ready): always ready; index 0 ripple_mode, 1
//   brightness_slot, others ignored. Write only while idle.
//  Reset: frame black, brightness 255, mode and slot 0, no output pending.
module led_ripple_frame_shifter #(
	parameter int LED_COUNT = lrfs_pkg::LED_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lrfs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lrfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic [7:0]                       color_red,
	input  logic [7:0]                       color_green,
	input  logic [7:0]                       color_blue,
	input  logic [lrfs_pkg::SLOT_W-1:0]      slot_index,
	input  logic [7:0]                       slot_value,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lrfs_pkg::PIX_INDEX_W-1:0] pixel_index,
	output logic [7:0]                       pixel_red,
	output logic [7:0]                       pixel_green,
	output logic [7:0]                       pixel_blue,
	output logic                             frame_last
);
	import lrfs_pkg::*;

	localparam int IDX_W = $clog2(LED_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

	mode_t               mode_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [7:0]          brightness_q;
	logic [IDX_W-1:0]    idx_q;
	logic                out_valid_q;

	logic       in_acc, tick_acc, out_acc, at_last, ro_free, load;
	logic       valid_s1;
	pixel_t     fill_s1;
	cell_ctrl_t ctrl;
	pixel_t     px [LED_COUNT];
	pixel_t     ro [LED_COUNT];

	// handshakes
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign tick_acc  = in_acc && (func == FUNC_TICK);
	assign out_acc   = out_valid_q && !out_stall;
	assign at_last   = (idx_q == LAST_IDX);
	// readout chain can take a new frame this cycle
	assign ro_free   = !out_valid_q || (out_acc && at_last);
	assign load      = valid_s1 && ro_free;
	assign in_stall  = valid_s1 && !ro_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TO_HIGH;
			slot_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_RIPPLE_MODE)
				mode_q <= mode_t'(cfg_data[1:0]);
			else if (cfg_index == REG_BRIGHTNESS_SLOT)
				slot_q <= cfg_data[SLOT_W-1:0];
		end
	end

	// brightness from matching control slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			brightness_q <= BRIGHTNESS_RST;
		else if (in_acc && func == FUNC_SLOT && slot_index == slot_q)
			brightness_q <= slot_value;
	end

	lrfs_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (tick_acc),
		.advance   (load),
		.brightness(brightness_q),
		.red       (color_red),
		.green     (color_green),
		.blue      (color_blue),
		.valid_s1  (valid_s1),
		.fill_s1   (fill_s1)
	);

	assign ctrl.mode     = mode_q;
	assign ctrl.apply    = load;
	assign ctrl.ro_shift = out_acc;

	// row of cells; neighbors beyond the ends are never selected
	for (genvar g = 0; g < LED_COUNT; g++) begin : g_cell
		pixel_t low_px, high_px, ro_in;
		if (g == 0) begin : g_lo_end
			assign low_px = '0;
		end else begin : g_lo
			assign low_px = px[g-1];
		end
		if (g == LED_COUNT - 1) begin : g_hi_end
			assign high_px = '0;
			assign ro_in   = '0;
		end else begin : g_hi
			assign high_px = px[g+1];
			assign ro_in   = ro[g+1];
		end
		lrfs_cell #(
			.INDEX    (g),
			.LED_COUNT(LED_COUNT)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.fill   (fill_s1),
			.low_px (low_px),
			.high_px(high_px),
			.ro_in  (ro_in),
			.px_q   (px[g]),
			.ro_q   (ro[g])
		);
	end

	// output sequencing: pixel counter and valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (out_acc) begin
			if (at_last)
				out_valid_q <= 1'b0;
			else
				idx_q <= idx_q + 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = PIX_INDEX_W'(idx_q);
	assign pixel_red   = ro[0].r;
	assign pixel_green = ro[0].g;
	assign pixel_blue  = ro[0].b;
	assign frame_last  = at_last;

	// a tick taken is held in the scale stage next cycle
	`LRFS_ASSERT_NXT(a_tick_held, clk, arst_n, tick_acc, valid_s1)
	// a waiting tick is not dropped while the readout is busy
	`LRFS_ASSERT_NXT(a_tick_kept, clk, arst_n, valid_s1 && !ro_free, valid_s1)
	// a frame load starts at pixel 0 with output valid
	`LRFS_ASSERT_NXT(a_load_start, clk, arst_n, load, out_valid && idx_q == '0)
	// last pixel taken without a new frame ends the output
	`LRFS_ASSERT_NXT(a_frame_end, clk, arst_n, out_acc && at_last && !load, !out_valid)

endmodule
